[hw/rtl/lcd_line_timing_controller_macros.svh]
// Assertion macros shared by the LCD line timing checkers.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef LCD_LINE_TIMING_CONTROLLER_MACROS_SVH
`define LCD_LINE_TIMING_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("LCD timing check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LCDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("LCD timing check failed in the next cycle");

`endif

[hw/rtl/lcdt_pkg.sv]
// Types, mode codes and default timing constants for the LCD line timing controller.
// Used by every module of the block; depends on nothing.
package lcdt_pkg;

  localparam int TICKS_PER_LINE = 114;
  localparam int VISIBLE_LINES  = 144;
  localparam int TOTAL_LINES    = 154;
  localparam int SCAN_END       = 20;
  localparam int TRANSFER_END   = 73;

  localparam int LINE_W = 8;

  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  localparam int IRQ_EN_HBLANK   = 0;
  localparam int IRQ_EN_VBLANK   = 1;
  localparam int IRQ_EN_OAM_SCAN = 2;
  localparam int IRQ_EN_MATCH    = 3;

  typedef struct packed {
    logic              lcd_enable;
    logic [LINE_W-1:0] line_compare;
    logic [3:0]        irq_enables;
  } lcdt_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    logic [1:0]        lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_line;
    logic              frame_done;
  } lcdt_out_t;

endpackage

[hw/rtl/lcdt_in_reg.sv]
// Input register stage of the LCD line timing controller.
// Depends on lcdt_pkg for the input item type.
module lcdt_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lcdt_pkg::lcdt_in_t in_item,
  input  logic               take,
  output logic               q_valid,
  output lcdt_pkg::lcdt_in_t q_item
);

  logic               q_valid_r;
  logic               q_valid_nxt;
  lcdt_pkg::lcdt_in_t q_item_r;
  logic               accept;

  assign in_stall = q_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (accept) begin
      q_valid_nxt = 1'b1;
    end else if (take) begin
      q_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item_r <= in_item;
    end
  end

  assign q_valid = q_valid_r;
  assign q_item  = q_item_r;

endmodule

[hw/rtl/lcdt_core.sv]
// Line and mode timing state with its next-state and result logic.
// Depends on lcdt_pkg for item types, mode codes and enable bit positions.
module lcdt_core #(
  parameter int TICKS_PER_LINE = lcdt_pkg::TICKS_PER_LINE,
  parameter int VISIBLE_LINES  = lcdt_pkg::VISIBLE_LINES,
  parameter int TOTAL_LINES    = lcdt_pkg::TOTAL_LINES,
  parameter int SCAN_END       = lcdt_pkg::SCAN_END,
  parameter int TRANSFER_END   = lcdt_pkg::TRANSFER_END
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lcdt_pkg::lcdt_in_t  item,
  output lcdt_pkg::lcdt_out_t result
);

  localparam int TICK_W = $clog2(TICKS_PER_LINE);
  localparam int LW     = lcdt_pkg::LINE_W;

  localparam logic [TICK_W:0] TICKS_L    = (TICK_W + 1)'(TICKS_PER_LINE);
  localparam logic [TICK_W:0] SCAN_L     = (TICK_W + 1)'(SCAN_END);
  localparam logic [TICK_W:0] TRANSFER_L = (TICK_W + 1)'(TRANSFER_END);
  localparam logic [LW:0]     VISIBLE_L  = (LW + 1)'(VISIBLE_LINES);
  localparam logic [LW:0]     TOTAL_L    = (LW + 1)'(TOTAL_LINES);

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [LW-1:0]     line_r, line_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              match_r, match_nxt;

  logic [1:0]        mode_pick;
  logic [TICK_W:0]   tick_inc;
  logic [LW:0]       line_inc;
  logic              line_end;
  logic              wrap;
  logic              vblank;
  logic              draw;
  logic              stat;

  always_comb begin
    priority if ({1'b0, line_r} >= VISIBLE_L) begin
      mode_pick = lcdt_pkg::MODE_VBLANK;
    end else if ({1'b0, tick_r} < SCAN_L) begin
      mode_pick = lcdt_pkg::MODE_OAM_SCAN;
    end else if ({1'b0, tick_r} < TRANSFER_L) begin
      mode_pick = lcdt_pkg::MODE_TRANSFER;
    end else begin
      mode_pick = lcdt_pkg::MODE_HBLANK;
    end
  end

  assign tick_inc = {1'b0, tick_r} + 1'b1;
  assign line_inc = {1'b0, line_r} + 1'b1;
  assign line_end = tick_inc >= TICKS_L;
  assign wrap     = (line_inc >= TOTAL_L) || line_inc[LW];

  always_comb begin
    tick_nxt  = tick_r;
    line_nxt  = line_r;
    mode_nxt  = mode_r;
    match_nxt = match_r;
    vblank    = 1'b0;
    draw      = 1'b0;
    stat      = 1'b0;
    if (!item.lcd_enable) begin
      tick_nxt = '0;
      line_nxt = '0;
    end else begin
      mode_nxt = mode_pick;
      tick_nxt = line_end ? '0 : tick_inc[TICK_W-1:0];
      if (line_end) begin
        draw      = {1'b0, line_r} < VISIBLE_L;
        match_nxt = line_r == item.line_compare;
        vblank    = line_inc == VISIBLE_L;
        line_nxt  = wrap ? '0 : line_inc[LW-1:0];
      end
      stat = (item.irq_enables[lcdt_pkg::IRQ_EN_MATCH] && match_nxt) ||
             (item.irq_enables[lcdt_pkg::IRQ_EN_OAM_SCAN] &&
              mode_nxt == lcdt_pkg::MODE_OAM_SCAN) ||
             (item.irq_enables[lcdt_pkg::IRQ_EN_VBLANK] &&
              mode_nxt == lcdt_pkg::MODE_VBLANK) ||
             (item.irq_enables[lcdt_pkg::IRQ_EN_HBLANK] &&
              mode_nxt == lcdt_pkg::MODE_HBLANK);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      line_r  <= '0;
      mode_r  <= lcdt_pkg::MODE_HBLANK;
      match_r <= 1'b0;
    end else if (step) begin
      tick_r  <= tick_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
    end
  end

  always_comb begin
    result.current_line = line_nxt;
    result.lcd_mode     = mode_nxt;
    result.coincidence  = match_nxt;
    result.vblank_irq   = vblank;
    result.stat_irq     = stat;
    result.draw_line    = draw;
    result.frame_done   = item.lcd_enable && line_end && wrap;
  end

endmodule

[hw/rtl/lcd_line_timing_controller.sv]
// LCD line timing controller: one result item for every tick item.
// A tick item waits in the input register; its result is registered in the output register as it leaves.
// Throughput is one item per cycle while out_stall is low; the line state updates as an item leaves the input register.
// Synchronous active-low reset clears the tick, line, mode and coincidence state and both valids.
// Depends on lcdt_pkg, lcdt_in_reg and lcdt_core.
module lcd_line_timing_controller #(
  parameter int TICKS_PER_LINE = lcdt_pkg::TICKS_PER_LINE,
  parameter int VISIBLE_LINES  = lcdt_pkg::VISIBLE_LINES,
  parameter int TOTAL_LINES    = lcdt_pkg::TOTAL_LINES,
  parameter int SCAN_END       = lcdt_pkg::SCAN_END,
  parameter int TRANSFER_END   = lcdt_pkg::TRANSFER_END
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdt_pkg::lcdt_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdt_pkg::lcdt_out_t out_item
);

  logic                q_valid;
  lcdt_pkg::lcdt_in_t  q_item;
  logic                load;
  lcdt_pkg::lcdt_out_t result;
  logic                out_valid_r, out_valid_nxt;
  lcdt_pkg::lcdt_out_t out_item_r;

  assign load = q_valid && (!out_valid_r || !out_stall);

  lcdt_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (load),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  lcdt_core #(
    .TICKS_PER_LINE (TICKS_PER_LINE),
    .VISIBLE_LINES  (VISIBLE_LINES),
    .TOTAL_LINES    (TOTAL_LINES),
    .SCAN_END       (SCAN_END),
    .TRANSFER_END   (TRANSFER_END)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (load),
    .item   (q_item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/lcdt_checker.sv]
// Port-level checks for the LCD line timing controller, bound to the top level.
// Depends on lcdt_pkg and the assertion macros header.
`include "lcd_line_timing_controller_macros.svh"

module lcdt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lcdt_pkg::lcdt_out_t out_item
);

  logic mode_not_vblank;

  assign mode_not_vblank = out_item.lcd_mode != lcdt_pkg::MODE_VBLANK;

  `LCDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `LCDT_ASSERT_SAME(a_wrap_line_zero, out_valid && out_item.frame_done, out_item.current_line == '0)
  `LCDT_ASSERT_SAME(a_vblank_draws, out_valid && out_item.vblank_irq, out_item.draw_line)
  `LCDT_ASSERT_SAME(a_vblank_mode_pair, out_valid && out_item.draw_line, mode_not_vblank)

endmodule

bind lcd_line_timing_controller lcdt_checker u_lcdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
